[sv/assert_macros.svh]
// assertion macros used by terminal_mst_bound.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is high
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// condition that must never be seen at a rising edge
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`endif

[sv/tmb_pkg.sv]
// shared widths, codes and constants of the terminal mst bound block
// no dependencies
package tmb_pkg;

   localparam int unsigned MAX_TERMINALS = 16;
   localparam int unsigned MAX_NODES_DEF = 256;
   localparam int unsigned DIST_BITS     = 24;

   localparam int unsigned COLS        = MAX_TERMINALS + 1;
   localparam int unsigned POS_BITS    = $clog2(COLS);
   localparam int unsigned EDGE_BITS   = DIST_BITS + 1;
   localparam int unsigned SUM_BITS    = 29;
   localparam int unsigned BOUND_BITS  = 28;
   localparam int unsigned RAM_DEPTH_DEF = MAX_NODES_DEF * COLS;

   localparam int unsigned KIND_BITS  = 1;
   localparam int unsigned NODE_BITS  = 8;
   localparam int unsigned COL_BITS   = 5;
   localparam int unsigned LABEL_BITS = 16;
   localparam int unsigned TC_BITS    = 5;

   localparam int unsigned CSR_IDX_BITS  = 1;
   localparam int unsigned CSR_DATA_BITS = 16;

   localparam logic [KIND_BITS-1:0] KIND_WRITE = 1'b0;
   localparam logic [KIND_BITS-1:0] KIND_QUERY = 1'b1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_TERMINAL_COUNT = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FULL_MASK      = 1'b1;

   localparam logic [TC_BITS-1:0]    TC_RESET = TC_BITS'(MAX_TERMINALS);
   localparam logic [LABEL_BITS-1:0] FM_RESET = '1;

   localparam logic [POS_BITS-1:0]  LAST_POS = POS_BITS'(COLS - 1);
   localparam logic [COL_BITS-1:0]  ROOT_COL = COL_BITS'(MAX_TERMINALS);
   localparam logic [EDGE_BITS-1:0] INF_EDGE = {1'b1, {DIST_BITS{1'b0}}};

endpackage

[sv/tmb_chan_if.sv]
// valid/ready channel interfaces: query/write input, bound output, register writes
// depends on tmb_pkg
interface tmb_req_if;
   import tmb_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [KIND_BITS-1:0]  kind;
   logic [NODE_BITS-1:0]  node;
   logic [COL_BITS-1:0]   column;
   logic [DIST_BITS-1:0]  distance;
   logic [LABEL_BITS-1:0] label;
   modport source (output valid, kind, node, column, distance, label, input ready);
   modport sink (input valid, kind, node, column, distance, label, output ready);
endinterface

interface tmb_rsp_if;
   import tmb_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [BOUND_BITS-1:0] bound;
   modport source (output valid, bound, input ready);
   modport sink (input valid, bound, output ready);
endinterface

interface tmb_csr_if;
   import tmb_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_BITS-1:0]  index;
   logic [CSR_DATA_BITS-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[sv/terminal_mst_bound.sv]
// top level: distance table in ram, prim mst sweep and nearest-two search per query
// depends on tmb_pkg, tmb_chan_if, tmb_ram, assert_macros.svh
//
//  channel   dir  transfer            payload
//  req_port  in   write or query      kind, node, column, distance, label
//  rsp_port  out  one per query       bound
//  csr_port  in   register write      index, data
//
// a write is done as it is taken; a query whose label equals full_mask reads only the
// root entry of its row; any other query runs the prim sweep and nearest-two search,
// reading at most one entry per cycle via the single ram read port; synchronous
// active-high reset clears control and presets csr registers; the table is not cleared
// a finished bound waits in the output register while the next transfer is taken
`include "assert_macros.svh"

module terminal_mst_bound_core #(
   parameter int unsigned MAX_NODES = tmb_pkg::MAX_NODES_DEF
) (
   input logic        clock,
   input logic        reset,
   tmb_req_if.sink    req_port,
   tmb_rsp_if.source  rsp_port,
   tmb_csr_if.sink    csr_port
);

   import tmb_pkg::*;

   localparam int unsigned DEPTH = MAX_NODES * COLS;
   localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [10:0] {
      S_IDLE       = 11'b00000000001,
      S_FULL       = 11'b00000000010,
      S_FULL_WAIT  = 11'b00000000100,
      S_PRIM       = 11'b00000001000,
      S_PRIM_DRAIN = 11'b00000010000,
      S_PRIM_NEXT  = 11'b00000100000,
      S_NEAR       = 11'b00001000000,
      S_NEAR_DRAIN = 11'b00010000000,
      S_ADD_FIRST  = 11'b00100000000,
      S_ADD_SECOND = 11'b01000000000,
      S_DONE       = 11'b10000000000
   } state_type;

   state_type             state_ff, state_in;
   logic [POS_BITS-1:0]   k_ff, k_in;
   logic [POS_BITS-1:0]   pick_ff, pick_in;
   logic [COLS-1:0]       in_tree_ff, in_tree_in;
   logic [EDGE_BITS-1:0]  best_ff [COLS];
   logic [EDGE_BITS-1:0]  best_in [COLS];
   logic [EDGE_BITS-1:0]  min_val_ff, min_val_in;
   logic [POS_BITS-1:0]   min_pos_ff, min_pos_in;
   logic [SUM_BITS-1:0]   sum_ff, sum_in;
   logic [DIST_BITS-1:0]  first_ff, first_in;
   logic [EDGE_BITS-1:0]  second_ff, second_in;
   logic [NODE_BITS-1:0]  node_ff, node_in;
   logic [LABEL_BITS-1:0] label_ff, label_in;
   logic                  full_ff, full_in;
   logic                  sv_vld_ff, sv_vld_in;
   logic                  sv_prim_ff, sv_prim_in;
   logic [POS_BITS-1:0]   sv_k_ff, sv_k_in;
   logic                  sv_zero_ff, sv_zero_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BOUND_BITS-1:0] rsp_bound_ff, rsp_bound_in;
   logic [TC_BITS-1:0]    tc_ff, tc_in;
   logic [LABEL_BITS-1:0] fm_ff, fm_in;

   logic [COLS-1:0]       active;
   logic [TC_BITS-1:0]    cnt;
   logic [NODE_BITS-1:0]  rd_row;
   logic [COL_BITS-1:0]   rd_col;
   logic                  iss_en;
   logic [AW-1:0]         rd_addr;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [DIST_BITS-1:0]  ram_rdata;
   logic [DIST_BITS-1:0]  d_val;
   logic [EDGE_BITS-1:0]  d_edge;
   logic [EDGE_BITS-1:0]  nb;
   logic                  req_xfer;
   logic                  in_sweep;
   logic                  in_prim;
   logic                  next_empty;
   logic                  next_pick;
   logic [POS_BITS-1:0]   tree_size;

   // vertex positions: 0 is the root, p is terminal p-1
   always_comb begin
      cnt = (tc_ff > TC_BITS'(MAX_TERMINALS)) ? TC_BITS'(MAX_TERMINALS) : tc_ff;
      active[0] = 1'b1;
      for (int p = 1; p < COLS; p++) begin
         active[p] = (TC_BITS'(p - 1) < cnt) && !label_ff[p - 1];
      end
   end

   // read address of the next table entry
   always_comb begin
      rd_row = node_ff;
      rd_col = ROOT_COL;
      iss_en = 1'b0;
      case (state_ff)
         S_PRIM: begin
            iss_en = active[k_ff] && !in_tree_ff[k_ff];
            if (pick_ff == '0) begin
               rd_row = NODE_BITS'(k_ff - POS_BITS'(1));
               rd_col = ROOT_COL;
            end else begin
               rd_row = NODE_BITS'(pick_ff - POS_BITS'(1));
               rd_col = (k_ff == '0) ? ROOT_COL : COL_BITS'(k_ff - POS_BITS'(1));
            end
         end
         S_NEAR: begin
            iss_en = active[k_ff];
            rd_col = (k_ff == '0) ? ROOT_COL : COL_BITS'(k_ff - POS_BITS'(1));
         end
         default: begin
         end
      endcase
   end

   assign rd_addr = AW'(32'(rd_row) * 32'(COLS) + 32'(rd_col));
   assign wr_addr = AW'(32'(req_port.node) * 32'(COLS) + 32'(req_port.column));

   assign req_xfer = req_port.valid && req_port.ready;
   assign wr_en    = req_xfer && (req_port.kind == KIND_WRITE)
                     && (req_port.column <= ROOT_COL)
                     && (32'(req_port.node) < MAX_NODES);

   tmb_ram #(
      .WIDTH (DIST_BITS),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_port.distance),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   // rows beyond the table read as zero
   assign d_val  = sv_zero_ff ? '0 : ram_rdata;
   assign d_edge = {1'b0, d_val};
   assign nb     = (d_edge < best_ff[sv_k_ff]) ? d_edge : best_ff[sv_k_ff];

   assign req_port.ready = (state_ff == S_IDLE);
   assign csr_port.ready = 1'b1;
   assign rsp_port.valid = rsp_valid_ff;
   assign rsp_port.bound = rsp_bound_ff;

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      pick_in      = pick_ff;
      in_tree_in   = in_tree_ff;
      best_in      = best_ff;
      min_val_in   = min_val_ff;
      min_pos_in   = min_pos_ff;
      sum_in       = sum_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      node_in      = node_ff;
      label_in     = label_ff;
      full_in      = full_ff;
      rsp_bound_in = rsp_bound_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      tc_in        = tc_ff;
      fm_in        = fm_ff;

      sv_vld_in  = iss_en;
      sv_prim_in = (state_ff == S_PRIM);
      sv_k_in    = k_ff;
      sv_zero_in = !(32'(rd_row) < MAX_NODES);

      if (csr_port.valid && csr_port.ready) begin
         case (csr_port.index)
            CSR_TERMINAL_COUNT: tc_in = csr_port.data[TC_BITS-1:0];
            CSR_FULL_MASK:      fm_in = csr_port.data;
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_xfer && req_port.kind == KIND_QUERY) begin
               node_in  = req_port.node;
               label_in = req_port.label;
               if (req_port.label == fm_ff) begin
                  full_in  = 1'b1;
                  state_in = S_FULL;
               end else begin
                  full_in    = 1'b0;
                  pick_in    = '0;
                  in_tree_in = COLS'(1);
                  for (int p = 0; p < COLS; p++) begin
                     best_in[p] = INF_EDGE;
                  end
                  min_val_in = INF_EDGE;
                  sum_in     = '0;
                  k_in       = '0;
                  state_in   = S_PRIM;
               end
            end
         end
         S_FULL: begin
            sv_zero_in = !(32'(node_ff) < MAX_NODES);
            state_in   = S_FULL_WAIT;
         end
         S_FULL_WAIT: begin
            sum_in   = SUM_BITS'(d_val);
            state_in = S_DONE;
         end
         S_PRIM: begin
            k_in = k_ff + POS_BITS'(1);
            if (k_ff == LAST_POS) begin
               k_in     = '0;
               state_in = S_PRIM_DRAIN;
            end
         end
         S_PRIM_DRAIN: begin
            state_in = S_PRIM_NEXT;
         end
         S_PRIM_NEXT: begin
            k_in = '0;
            if (min_val_ff != INF_EDGE) begin
               pick_in                = min_pos_ff;
               in_tree_in[min_pos_ff] = 1'b1;
               sum_in                 = sum_ff + SUM_BITS'(min_val_ff);
               min_val_in             = INF_EDGE;
               state_in               = S_PRIM;
            end else begin
               second_in = INF_EDGE;
               state_in  = S_NEAR;
            end
         end
         S_NEAR: begin
            k_in = k_ff + POS_BITS'(1);
            if (k_ff == LAST_POS) begin
               k_in     = '0;
               state_in = S_NEAR_DRAIN;
            end
         end
         S_NEAR_DRAIN: begin
            state_in = S_ADD_FIRST;
         end
         S_ADD_FIRST: begin
            sum_in   = sum_ff + SUM_BITS'(first_ff);
            state_in = S_ADD_SECOND;
         end
         S_ADD_SECOND: begin
            if (second_ff != INF_EDGE) begin
               sum_in = sum_ff + SUM_BITS'(second_ff);
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_bound_in = full_ff ? sum_ff[BOUND_BITS-1:0] : sum_ff[SUM_BITS-1:1];
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // data of the entry issued in the previous cycle
      if (sv_vld_ff) begin
         if (sv_prim_ff) begin
            best_in[sv_k_ff] = nb;
            if (nb < min_val_ff) begin
               min_val_in = nb;
               min_pos_in = sv_k_ff;
            end
         end else if (sv_k_ff == '0) begin
            first_in = d_val;
         end else if (d_val < first_ff) begin
            second_in = {1'b0, first_ff};
            first_in  = d_val;
         end else if (d_edge < second_ff) begin
            second_in = d_edge;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         in_tree_ff   <= '0;
         sv_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tc_ff        <= TC_RESET;
         fm_ff        <= FM_RESET;
      end else begin
         state_ff     <= state_in;
         in_tree_ff   <= in_tree_in;
         sv_vld_ff    <= sv_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         tc_ff        <= tc_in;
         fm_ff        <= fm_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      pick_ff      <= pick_in;
      best_ff      <= best_in;
      min_val_ff   <= min_val_in;
      min_pos_ff   <= min_pos_in;
      sum_ff       <= sum_in;
      first_ff     <= first_in;
      second_ff    <= second_in;
      node_ff      <= node_in;
      label_ff     <= label_in;
      full_ff      <= full_in;
      sv_prim_ff   <= sv_prim_in;
      sv_k_ff      <= sv_k_in;
      sv_zero_ff   <= sv_zero_in;
      rsp_bound_ff <= rsp_bound_in;
   end

   assign in_sweep   = state_ff inside {S_PRIM, S_PRIM_DRAIN, S_NEAR, S_NEAR_DRAIN};
   assign in_prim    = (state_ff == S_PRIM);
   assign next_empty = (state_ff == S_PRIM_NEXT) && (min_val_ff == INF_EDGE);
   assign next_pick  = (state_ff == S_PRIM_NEXT) && (min_val_ff != INF_EDGE);
   assign tree_size  = POS_BITS'($countones(in_tree_ff));

   `ASSERT_PROP(a_sweep_data_in_sweep, clock, reset, sv_vld_ff |-> in_sweep)
   `ASSERT_PROP(a_pick_in_tree, clock, reset, in_prim |-> (in_tree_ff[pick_ff] && active[pick_ff]))
   `ASSERT_PROP(a_tree_complete, clock, reset, next_empty |-> (in_tree_ff == active))
   `ASSERT_PROP(a_tree_grows, clock, reset, next_pick |=> (tree_size == $past(tree_size) + 1'b1))

endmodule

[sv/tmb_ram.sv]
// generic single-clock ram, one write port, one read port, registered read data
// depends on tmb_pkg for default sizes
module tmb_ram #(
   parameter int unsigned WIDTH = tmb_pkg::DIST_BITS,
   parameter int unsigned DEPTH = tmb_pkg::RAM_DEPTH_DEF,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[tb/tb_terminal_mst_bound_core.sv]
// self-checking testbench for terminal_mst_bound_core: table writes, bound queries, csr settings
// predicts each bound from its own copy of the table and registers
// depends on tmb_pkg, tmb_chan_if and the rtl of the block
module tb_terminal_mst_bound_core;
   timeunit 1ns;
   timeprecision 1ps;
   import tmb_pkg::*;

   localparam int RESET_CYCLES  = 8;
   localparam int SETTLE_CYCLES = 16;
   localparam int STALL_LIMIT   = 20000;
   localparam int PHASE_ITEMS   = 220;
   localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

   typedef enum {FILL_RANDOM, FILL_MAX, FILL_ZERO} fill_type;

   logic clock = 1'b0;
   logic reset;

   tmb_req_if req_if();
   tmb_rsp_if rsp_if();
   tmb_csr_if csr_if();

   terminal_mst_bound_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   logic [DIST_BITS-1:0]  dist_tab [MAX_NODES_DEF][COLS];
   logic [TC_BITS-1:0]    tc_cfg;
   logic [LABEL_BITS-1:0] fm_cfg;
   logic [BOUND_BITS-1:0] bound_q [$];
   logic [NODE_BITS-1:0]  loaded_rows [$];
   bit                    row_loaded [MAX_NODES_DEF];
   bit                    req_gaps_on;
   bit                    rsp_stalls_on;
   int                    mismatches;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic [DIST_BITS-1:0] pick_distance();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return DIST_MAX;
      if (r == 2) return DIST_BITS'($urandom_range(0, 15));
      return DIST_BITS'($urandom);
   endfunction

   function automatic logic [LABEL_BITS-1:0] pick_label();
      int                    cnt;
      logic [LABEL_BITS-1:0] covered_all;
      cnt = (tc_cfg > MAX_TERMINALS) ? MAX_TERMINALS : tc_cfg;
      covered_all = LABEL_BITS'((32'h1 << cnt) - 1);
      case ($urandom_range(0, 5))
         0: return fm_cfg;
         1: return covered_all | (LABEL_BITS'($urandom) & ~covered_all);
         2: return LABEL_BITS'($urandom | $urandom);
         3: return LABEL_BITS'($urandom & $urandom);
         default: return LABEL_BITS'($urandom);
      endcase
   endfunction

   // half of prim over root and open terminals plus the two nearest; root distance on full_mask
   function automatic logic [BOUND_BITS-1:0] bound_for(input logic [NODE_BITS-1:0] node,
                                                      input logic [LABEL_BITS-1:0] label);
      logic [COL_BITS-1:0]  vert  [COLS];
      logic [EDGE_BITS-1:0] reach [COLS];
      bit                   joined [COLS];
      logic [EDGE_BITS-1:0] low, d, first, second;
      logic [63:0]          total;
      int                   nv, cnt, pick;
      if (label == fm_cfg) return BOUND_BITS'(dist_tab[node][ROOT_COL]);
      cnt = (tc_cfg > MAX_TERMINALS) ? MAX_TERMINALS : tc_cfg;
      vert[0] = ROOT_COL;
      nv = 1;
      for (int t = 0; t < cnt; t++) begin
         if (!label[t]) begin
            vert[nv] = COL_BITS'(t);
            nv++;
         end
      end
      for (int i = 0; i < nv; i++) begin
         reach[i] = INF_EDGE;
         joined[i] = 1'b0;
      end
      reach[0] = '0;
      total = '0;
      for (int i = 0; i < nv; i++) begin
         low = INF_EDGE;
         pick = 0;
         for (int k = 0; k < nv; k++) begin
            if (!joined[k] && reach[k] < low) begin
               low = reach[k];
               pick = k;
            end
         end
         if (low == INF_EDGE) break;
         joined[pick] = 1'b1;
         reach[pick] = INF_EDGE;
         total += low;
         for (int k = 0; k < nv; k++) begin
            if (!joined[k]) begin
               if (vert[pick] == ROOT_COL) d = {1'b0, dist_tab[vert[k]][ROOT_COL]};
               else d = {1'b0, dist_tab[vert[pick]][vert[k]]};
               if (d < reach[k]) reach[k] = d;
            end
         end
      end
      first = {1'b0, dist_tab[node][ROOT_COL]};
      second = INF_EDGE;
      for (int t = 0; t < cnt; t++) begin
         if (!label[t]) begin
            d = {1'b0, dist_tab[node][t]};
            if (d < first) begin
               second = first;
               first = d;
            end else if (d < second) begin
               second = d;
            end
         end
      end
      total += first;
      if (second != INF_EDGE) total += second;
      return BOUND_BITS'(total >> 1);
   endfunction

   task automatic send_item(input logic [KIND_BITS-1:0]  kind,
                            input logic [NODE_BITS-1:0]  node,
                            input logic [COL_BITS-1:0]   column,
                            input logic [DIST_BITS-1:0]  distance,
                            input logic [LABEL_BITS-1:0] label);
      int gap;
      gap = req_gaps_on ? draw_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid    = 1'b1;
      req_if.kind     = kind;
      req_if.node     = node;
      req_if.column   = column;
      req_if.distance = distance;
      req_if.label    = label;
      do @(posedge clock); while (!req_if.ready);
      if (kind == KIND_WRITE) begin
         if (column < COLS) dist_tab[node][column] = distance;
      end else begin
         bound_q = {bound_q, bound_for(node, label)};
      end
   endtask

   task automatic send_query(input logic [NODE_BITS-1:0] node,
                             input logic [LABEL_BITS-1:0] label);
      send_item(KIND_QUERY, node, COL_BITS'($urandom), DIST_BITS'($urandom), label);
   endtask

   task automatic send_write(input logic [NODE_BITS-1:0] node,
                             input logic [COL_BITS-1:0]  column,
                             input logic [DIST_BITS-1:0] distance);
      send_item(KIND_WRITE, node, column, distance, LABEL_BITS'($urandom));
   endtask

   task automatic fill_row(input logic [NODE_BITS-1:0] node, input fill_type fill);
      logic [DIST_BITS-1:0] d;
      for (int c = 0; c < COLS; c++) begin
         case (fill)
            FILL_MAX: d = DIST_MAX;
            FILL_ZERO: d = '0;
            default: d = pick_distance();
         endcase
         send_write(node, COL_BITS'(c), d);
      end
      if (!row_loaded[node]) begin
         row_loaded[node] = 1'b1;
         loaded_rows = {loaded_rows, node};
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (bound_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0]  reg_idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_if.valid = 1'b1;
      csr_if.index = reg_idx;
      csr_if.data  = data;
      do @(posedge clock); while (!csr_if.ready);
      if (reg_idx == CSR_TERMINAL_COUNT) tc_cfg = data[TC_BITS-1:0];
      else fm_cfg = data[LABEL_BITS-1:0];
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   task automatic set_config(input logic [CSR_DATA_BITS-1:0] tc_data,
                             input logic [CSR_DATA_BITS-1:0] mask);
      wait_idle();
      write_csr(CSR_TERMINAL_COUNT, tc_data);
      write_csr(CSR_FULL_MASK, mask);
   endtask

   task automatic check_bound(input logic [BOUND_BITS-1:0] got);
      logic [BOUND_BITS-1:0] want;
      if (bound_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("bound %0d arrived with no query pending", got);
      end else begin
         want = bound_q.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("bound mismatch: expected %0d, actual %0d", want, got);
         end
      end
   endtask

   task automatic test_table_load();
      req_gaps_on = 1'b1;
      rsp_stalls_on = 1'b1;
      for (int t = 0; t < MAX_TERMINALS; t++) fill_row(NODE_BITS'(t), FILL_RANDOM);
      fill_row(8'd127, FILL_RANDOM);
      fill_row(8'd128, FILL_RANDOM);
      fill_row(8'd255, FILL_RANDOM);
      fill_row(8'd200, FILL_MAX);
      fill_row(8'd201, FILL_ZERO);
   endtask

   task automatic test_special_cases();
      send_query(8'd0, 16'h0000);
      send_query(8'd255, 16'hFFFF);
      send_query(8'd200, 16'h0000);
      send_query(8'd201, 16'h0000);
      send_query(8'd128, 16'h8000);
      send_query(8'd127, 16'hFFFE);
      // writes past the root column are dropped
      send_write(8'd3, 5'd17, DIST_BITS'($urandom));
      send_write(8'd3, 5'd31, DIST_BITS'($urandom));
      send_query(8'd3, 16'h0000);
      send_write(8'd3, ROOT_COL, DIST_MAX);
      send_write(8'd3, 5'd0, '0);
      send_query(8'd3, 16'h0000);
      // root only
      set_config(16'h0000, 16'hFFFF);
      send_query(8'd15, 16'h1234);
      // count above the table width acts as sixteen
      set_config(16'hFFF1, 16'h0000);
      send_query(8'd7, 16'h0000);
      send_query(8'd7, 16'hFFFF);
      // labels above the count are ignored; no open terminal left
      set_config(16'h0005, 16'h001F);
      send_query(8'd9, 16'hFFE0);
      send_query(8'd9, 16'h001F);
      send_query(8'd9, 16'h003F);
      send_query(8'd9, 16'h0010);
      set_config(16'h001F, CSR_DATA_BITS'($urandom));
      send_query(8'd255, 16'h00FF);
   endtask

   task automatic test_max_bound();
      set_config(16'h0010, 16'hFFFF);
      for (int t = 0; t < MAX_TERMINALS; t++) fill_row(NODE_BITS'(t), FILL_MAX);
      send_query(8'd200, 16'h0000);
      send_query(8'd201, 16'h5555);
      for (int t = 0; t < MAX_TERMINALS; t++) fill_row(NODE_BITS'(t), FILL_RANDOM);
   endtask

   task automatic test_random_phases();
      int                   count, r, tc;
      logic [NODE_BITS-1:0] node;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               req_gaps_on = 1'b1;
               rsp_stalls_on = 1'b1;
               set_config(16'h0010, 16'hFFFF);
            end
            1: begin
               req_gaps_on = 1'b0;
               rsp_stalls_on = 1'b0;
               tc = $urandom_range(1, MAX_TERMINALS);
               set_config(CSR_DATA_BITS'(tc), CSR_DATA_BITS'((32'h1 << tc) - 1));
            end
            2: begin
               req_gaps_on = 1'b1;
               rsp_stalls_on = 1'b0;
               set_config(CSR_DATA_BITS'($urandom), CSR_DATA_BITS'($urandom));
            end
            3: begin
               req_gaps_on = 1'b0;
               rsp_stalls_on = 1'b1;
               set_config(CSR_DATA_BITS'($urandom_range(17, 31)), 16'h0000);
            end
            default: begin
               req_gaps_on = 1'b1;
               rsp_stalls_on = 1'b1;
               set_config(16'h0001, CSR_DATA_BITS'($urandom));
            end
         endcase
         count = 0;
         while (count < PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 2) begin
               wait_idle();
            end else if (r < 10) begin
               node = NODE_BITS'($urandom);
               fill_row(node, FILL_RANDOM);
               send_query(node, pick_label());
               count += COLS + 1;
            end else if (r < 45) begin
               send_write(NODE_BITS'($urandom), COL_BITS'($urandom_range(0, COLS - 1)),
                          pick_distance());
               count++;
            end else if (r < 52) begin
               send_write(NODE_BITS'($urandom), COL_BITS'($urandom_range(COLS, 31)),
                          DIST_BITS'($urandom));
            end else begin
               send_query(loaded_rows[$urandom_range(0, loaded_rows.size() - 1)],
                          pick_label());
               count++;
            end
         end
      end
   endtask

   initial begin : bound_sink
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (!rsp_stalls_on) begin
            rsp_if.ready = 1'b1;
         end else if (hold > 0) begin
            rsp_if.ready = 1'b0;
            hold--;
         end else begin
            rsp_if.ready = 1'b1;
            hold = draw_gap();
         end
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) check_bound(rsp_if.bound);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready)) quiet = 0;
         else quiet++;
      end
      $display("tb_terminal_mst_bound_core: done, errors");
      $finish;
   end

   initial begin
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.kind     = KIND_WRITE;
      req_if.node     = '0;
      req_if.column   = '0;
      req_if.distance = '0;
      req_if.label    = '0;
      rsp_if.ready    = 1'b0;
      csr_if.valid    = 1'b0;
      csr_if.index    = CSR_TERMINAL_COUNT;
      csr_if.data     = '0;
      req_gaps_on     = 1'b0;
      rsp_stalls_on   = 1'b0;
      mismatches      = 0;
      tc_cfg          = TC_RESET;
      fm_cfg          = FM_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_table_load();
      test_special_cases();
      test_max_bound();
      test_random_phases();
      wait_idle();
      if (mismatches == 0) begin
         $display("tb_terminal_mst_bound_core: done, clean");
      end else begin
         $display("tb_terminal_mst_bound_core: done, errors");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+sv
sv/tmb_pkg.sv
sv/tmb_chan_if.sv
sv/tmb_ram.sv
sv/terminal_mst_bound.sv
tb/tb_terminal_mst_bound_core.sv
